@@ design/wls_pkg.sv @@
`timescale 1ns / 1ps
package wls_pkg;

   localparam int COUNT_BITS = 24;
   localparam int INDEX_BITS = 10;
   localparam int THRESH_BITS = 24;
   localparam int MODE_BITS = 2;
   localparam int DATA_BITS = 32;
   localparam int ADDR_BITS = 3;

   localparam logic [MODE_BITS-1:0] MODE_DYNAMIC = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_STATIC = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_HYBRID = 2'd2;

   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_MODE = 1'b1;

   typedef struct packed {
      logic [COUNT_BITS-1:0] wear_count;
      logic                  last_block;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] min_count;
      logic [COUNT_BITS-1:0] max_count;
      logic [COUNT_BITS-1:0] spread;
      logic [INDEX_BITS-1:0] least_worn_block;
      logic [INDEX_BITS-1:0] cold_block;
      logic [INDEX_BITS-1:0] hot_block;
      logic                  rebalance;
      logic                  counts_rewritten;
      logic [COUNT_BITS-1:0] new_hot_count;
      logic [COUNT_BITS-1:0] new_cold_count;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] min_count;
      logic [COUNT_BITS-1:0] max_count;
      logic [INDEX_BITS-1:0] first_min;
      logic [INDEX_BITS-1:0] last_min;
      logic [INDEX_BITS-1:0] last_max;
   } scan_type;

endpackage

@@ design/wear_level_scan.sv @@
`timescale 1ns / 1ps
// wear_level_scan: min/max erase-count monitor for wear leveling
// req channel: one item per flash block in index order, wear_count and
//   last_block; the item with last_block set closes the scan and is counted
// rsp channel: one item per scan with min, max, spread, least-worn, cold
//   and hot block indices, rebalance flag and the rewritten counts
// csr port: APB-style, byte 0 spread_threshold, byte 4 level_mode;
//   pready is always high; the user writes only while the block is idle, the block does not enforce it
// throughput: one req item per cycle while req_ready is high, set by the
//   running compare-and-update of the extremes and the block counter
// result path: the closing req item's scan goes into the scan capture
//   register, then into the result register, where the rsp item is valid
// stall: while rsp is held and the capture register is full, req_ready
//   drops; no item is lost or repeated
// reset: clears the scan state and both valid flags, not the register data;
//   no clearing pass is needed
module wear_level_scan
   import wls_pkg::*;
#(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   localparam int CTR_BITS = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
   localparam logic [CTR_BITS-1:0] CTR_LAST = CTR_BITS'(NUM_BLOCKS - 1);

   logic [THRESH_BITS-1:0] threshold_ff;
   logic [MODE_BITS-1:0]   mode_ff;

   logic [COUNT_BITS-1:0] run_min_ff, run_min_in;
   logic [COUNT_BITS-1:0] run_max_ff, run_max_in;
   logic [INDEX_BITS-1:0] first_min_ff, first_min_in;
   logic [INDEX_BITS-1:0] last_min_ff, last_min_in;
   logic [INDEX_BITS-1:0] last_max_ff, last_max_in;
   logic [CTR_BITS-1:0]   counter_ff, counter_in;

   scan_type s1_ff, s1_in;
   logic     s1_valid_ff, s1_valid_in;
   rsp_type  rsp_ff, rsp_in;
   logic     rsp_valid_ff, rsp_valid_in;

   logic                  req_accept;
   logic                  out_free;
   logic                  s1_advance;
   logic [INDEX_BITS-1:0] idx;
   logic                  csr_write;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == REG_MODE) ? DATA_BITS'(mode_ff) : DATA_BITS'(threshold_ff);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;
   assign idx = INDEX_BITS'(counter_ff);

   // running extremes with the current item folded in
   always_comb begin
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      first_min_in = first_min_ff;
      last_min_in = last_min_ff;
      last_max_in = last_max_ff;
      if (req_data.wear_count < run_min_ff) begin
         run_min_in = req_data.wear_count;
         first_min_in = idx;
         last_min_in = idx;
      end else if (req_data.wear_count == run_min_ff) begin
         last_min_in = idx;
      end
      if (req_data.wear_count >= run_max_ff) begin
         run_max_in = req_data.wear_count;
         last_max_in = idx;
      end
      counter_in = (counter_ff == CTR_LAST) ? '0 : counter_ff + 1'b1;
   end

   always_comb begin
      s1_in.min_count = run_min_in;
      s1_in.max_count = run_max_in;
      s1_in.first_min = first_min_in;
      s1_in.last_min = last_min_in;
      s1_in.last_max = last_max_in;
      if (req_accept && req_data.last_block) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // result from the captured scan
   always_comb begin
      logic [COUNT_BITS-1:0] spread;
      logic [COUNT_BITS-1:0] hot_new;
      logic [COUNT_BITS-1:0] cold_base;
      logic                  reb;
      logic                  rewrite;
      spread = s1_ff.max_count - s1_ff.min_count;
      reb = spread >= COUNT_BITS'(threshold_ff);
      rewrite = reb && (mode_ff == MODE_STATIC || mode_ff == MODE_HYBRID);
      hot_new = s1_ff.max_count >> 1;
      cold_base = (spread == '0) ? hot_new : s1_ff.min_count;
      rsp_in.min_count = s1_ff.min_count;
      rsp_in.max_count = s1_ff.max_count;
      rsp_in.spread = spread;
      rsp_in.least_worn_block = s1_ff.first_min;
      rsp_in.cold_block = s1_ff.last_min;
      rsp_in.hot_block = s1_ff.last_max;
      rsp_in.rebalance = reb;
      rsp_in.counts_rewritten = rewrite;
      rsp_in.new_hot_count = '0;
      rsp_in.new_cold_count = '0;
      if (rewrite) begin
         rsp_in.new_hot_count = hot_new;
         rsp_in.new_cold_count = cold_base[COUNT_BITS-1] ? '1 :
                                 {cold_base[COUNT_BITS-2:0], 1'b0};
      end
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         mode_ff <= MODE_DYNAMIC;
      end else if (csr_write) begin
         if (paddr[2] == REG_THRESHOLD) begin
            threshold_ff <= pwdata[THRESH_BITS-1:0];
         end else begin
            mode_ff <= pwdata[MODE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff <= '1;
         run_max_ff <= '0;
         first_min_ff <= '0;
         last_min_ff <= '0;
         last_max_ff <= '0;
         counter_ff <= '0;
      end else if (req_accept) begin
         if (req_data.last_block) begin
            run_min_ff <= '1;
            run_max_ff <= '0;
            first_min_ff <= '0;
            last_min_ff <= '0;
            last_max_ff <= '0;
            counter_ff <= '0;
         end else begin
            run_min_ff <= run_min_in;
            run_max_ff <= run_max_in;
            first_min_ff <= first_min_in;
            last_min_ff <= last_min_in;
            last_max_ff <= last_max_in;
            counter_ff <= counter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_data.last_block) begin
         s1_ff <= s1_in;
      end
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef ASSERT_OFF
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("req taken while capture register is blocked");

   a_reset_clears_scan: assert property (@(posedge clock)
      reset |=> (counter_ff == '0 && run_min_ff == '1 && run_max_ff == '0))
      else $error("scan state not cleared by reset");

   a_last_closes_scan: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last_block) |=> (s1_valid_ff && counter_ff == '0))
      else $error("closing item did not start a new scan");

   a_capture_ordered: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_ff.max_count >= s1_ff.min_count))
      else $error("captured maximum below minimum");

   a_rewrite_needs_rebalance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.rebalance) |->
         (!rsp_ff.counts_rewritten && rsp_ff.new_hot_count == '0
          && rsp_ff.new_cold_count == '0))
      else $error("counts rewritten without rebalance");
`endif

endmodule

@@ tb/tb_wear_level_scan.sv @@
`timescale 1ns / 1ps
module tb_wear_level_scan;
   import wls_pkg::*;

   localparam int NUM_BLOCKS = 1024;
   localparam int RANDOM_ITEMS = 1700;
   localparam int CYCLE_LIMIT = 300000;
   localparam int IDLE_PERCENT = 12;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum {SHAPE_WIDE, SHAPE_TIGHT, SHAPE_NEAR_TOP, SHAPE_EXTREMES} count_shape_type;

   class scan_tracker_type;
      logic [THRESH_BITS-1:0] threshold;
      logic [MODE_BITS-1:0]   mode;
      logic [COUNT_BITS-1:0]  low_count;
      logic [COUNT_BITS-1:0]  high_count;
      logic [INDEX_BITS-1:0]  first_low_idx;
      logic [INDEX_BITS-1:0]  last_low_idx;
      logic [INDEX_BITS-1:0]  last_high_idx;
      int                     position;
      rsp_type                pending_summaries[$];
      int                     blocks_seen;
      int                     summaries_checked;
      int                     mismatches;

      function new();
         threshold = '0;
         mode = MODE_DYNAMIC;
         blocks_seen = 0;
         summaries_checked = 0;
         mismatches = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         low_count = COUNT_MAX;
         high_count = '0;
         first_low_idx = '0;
         last_low_idx = '0;
         last_high_idx = '0;
         position = 0;
      endfunction

      function void set_reg(logic idx, logic [DATA_BITS-1:0] value);
         if (idx == REG_THRESHOLD) begin
            threshold = value[THRESH_BITS-1:0];
         end else begin
            mode = value[MODE_BITS-1:0];
         end
      endfunction

      function void note_block(req_type item);
         logic [INDEX_BITS-1:0] idx;
         logic [COUNT_BITS-1:0] gap;
         logic [COUNT_BITS-1:0] cold_base;
         logic [COUNT_BITS:0]   doubled;
         rsp_type               summary;
         idx = position[INDEX_BITS-1:0];
         blocks_seen++;
         if (item.wear_count < low_count) begin
            low_count = item.wear_count;
            first_low_idx = idx;
            last_low_idx = idx;
         end else if (item.wear_count == low_count) begin
            last_low_idx = idx;
         end
         if (item.wear_count >= high_count) begin
            high_count = item.wear_count;
            last_high_idx = idx;
         end
         position = (position + 1 >= NUM_BLOCKS) ? 0 : position + 1;
         if (item.last_block) begin
            gap = high_count - low_count;
            summary.min_count = low_count;
            summary.max_count = high_count;
            summary.spread = gap;
            summary.least_worn_block = first_low_idx;
            summary.cold_block = last_low_idx;
            summary.hot_block = last_high_idx;
            summary.rebalance = (gap >= threshold);
            summary.counts_rewritten = summary.rebalance &&
               (mode == MODE_STATIC || mode == MODE_HYBRID);
            summary.new_hot_count = '0;
            summary.new_cold_count = '0;
            if (summary.counts_rewritten) begin
               // halving comes first, so a zero spread doubles the halved count
               summary.new_hot_count = high_count >> 1;
               cold_base = (gap == 0) ? (high_count >> 1) : low_count;
               doubled = {cold_base, 1'b0};
               summary.new_cold_count = doubled[COUNT_BITS] ? COUNT_MAX :
                  doubled[COUNT_BITS-1:0];
            end
            pending_summaries.push_back(summary);
            clear_scan();
         end
      endfunction

      function void compare_field(string field, logic [COUNT_BITS-1:0] want,
                                  logic [COUNT_BITS-1:0] got);
         if (want !== got) begin
            if (mismatches < 10) begin
               $display("scan %0d: %s expected %h, got %h", summaries_checked, field,
                        want, got);
            end
            mismatches++;
         end
      endfunction

      function void check_summary(rsp_type got);
         rsp_type want;
         if (pending_summaries.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected result item: %h", got);
            end
            mismatches++;
         end else begin
            want = pending_summaries.pop_front();
            compare_field("min_count", want.min_count, got.min_count);
            compare_field("max_count", want.max_count, got.max_count);
            compare_field("spread", want.spread, got.spread);
            compare_field("least_worn_block", COUNT_BITS'(want.least_worn_block),
                          COUNT_BITS'(got.least_worn_block));
            compare_field("cold_block", COUNT_BITS'(want.cold_block),
                          COUNT_BITS'(got.cold_block));
            compare_field("hot_block", COUNT_BITS'(want.hot_block),
                          COUNT_BITS'(got.hot_block));
            compare_field("rebalance", COUNT_BITS'(want.rebalance),
                          COUNT_BITS'(got.rebalance));
            compare_field("counts_rewritten", COUNT_BITS'(want.counts_rewritten),
                          COUNT_BITS'(got.counts_rewritten));
            compare_field("new_hot_count", want.new_hot_count, got.new_hot_count);
            compare_field("new_cold_count", want.new_cold_count, got.new_cold_count);
            summaries_checked++;
         end
      endfunction

      function int pending();
         return pending_summaries.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [ADDR_BITS-1:0] paddr;
   logic [DATA_BITS-1:0] pwdata;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   scan_tracker_type tracker = new();
   int               cycle_count = 0;
   int               hold_left = 0;
   logic             no_idle = 1'b0;
   int               settings_used = 0;

   wear_level_scan #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  tracker.pending());
         $display("[wear_level_scan] ERROR");
         $finish;
      end
   end

   // result side: random stalls plus a long hold-off on request
   always begin
      @(negedge clock);
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_summary(rsp_data);
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic [COUNT_BITS-1:0] cnt, input logic last);
      req_type item;
      item.wear_count = cnt;
      item.last_block = last;
      if (!no_idle) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_block(item);
      @(negedge clock);
   endtask

   task automatic run_scan(input int length, input count_shape_type shape);
      logic [COUNT_BITS-1:0] cnt;
      for (int n = 0; n < length; n++) begin
         case (shape)
            SHAPE_WIDE: cnt = COUNT_BITS'($urandom);
            SHAPE_TIGHT: cnt = COUNT_BITS'($urandom_range(7));
            SHAPE_NEAR_TOP: cnt = COUNT_MAX - COUNT_BITS'($urandom_range(7));
            default: begin
               case ($urandom_range(2))
                  0: cnt = '0;
                  1: cnt = COUNT_MAX;
                  default: cnt = COUNT_BITS'($urandom);
               endcase
            end
         endcase
         send_item(cnt, n == length - 1);
      end
   endtask

   task automatic write_reg(input logic idx, input logic [DATA_BITS-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tracker.set_reg(idx, value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // unused upper data bits carry noise, the block keeps only the field
   task automatic configure(input logic [THRESH_BITS-1:0] thr,
                            input logic [MODE_BITS-1:0] mode);
      wait_drained();
      write_reg(REG_THRESHOLD, {8'($urandom_range(255)), thr});
      write_reg(REG_MODE, ($urandom & ~32'h3) | DATA_BITS'(mode));
      settings_used++;
   endtask

   initial begin
      logic [MODE_BITS-1:0]   modes[4];
      logic [THRESH_BITS-1:0] thr;
      int                     random_items;
      int                     phase_items;
      int                     phase;
      int                     len;
      modes = '{MODE_DYNAMIC, MODE_STATIC, MODE_HYBRID, MODE_UNUSED};
      random_items = 0;
      phase = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all-ones first block, single block, ties, saturation, full spread, then the other modes
      configure('0, MODE_STATIC);
      send_item(COUNT_MAX, 1'b0);
      send_item(COUNT_MAX, 1'b1);
      send_item('0, 1'b1);
      send_item(24'd5, 1'b0);
      send_item(24'd3, 1'b0);
      send_item(24'd9, 1'b0);
      send_item(24'd3, 1'b0);
      send_item(24'd9, 1'b0);
      send_item(24'd4, 1'b1);
      send_item(COUNT_MAX - 24'd15, 1'b0);
      send_item(COUNT_MAX, 1'b1);
      send_item('0, 1'b0);
      send_item(COUNT_MAX, 1'b1);
      configure(COUNT_MAX, MODE_HYBRID);
      send_item('0, 1'b0);
      send_item(COUNT_MAX, 1'b1);
      send_item(24'd1, 1'b0);
      send_item(24'd2, 1'b1);
      configure('0, MODE_UNUSED);
      send_item(24'd7, 1'b0);
      send_item(24'd1, 1'b1);
      configure(24'd5, MODE_DYNAMIC);
      send_item(24'd4, 1'b0);
      send_item(24'd4, 1'b1);
      send_item(24'd3, 1'b0);
      send_item(24'd9, 1'b1);

      while (random_items < RANDOM_ITEMS) begin
         case (phase % 5)
            0: thr = '0;
            1: thr = COUNT_MAX;
            2: thr = THRESH_BITS'($urandom);
            3: thr = THRESH_BITS'($urandom_range(8));
            default: thr = THRESH_BITS'($urandom_range(1 << 20));
         endcase
         configure(thr, modes[phase % 4]);
         no_idle = (phase == 2);
         phase_items = 0;
         if (phase == 1) begin
            // receiver stalls while single-block scans keep arriving
            hold_left = 120;
            repeat (40) run_scan(1, SHAPE_WIDE);
            phase_items += 40;
         end
         if (phase == 3) begin
            // block index wraps past the last block
            len = NUM_BLOCKS + $urandom_range(8, 40);
            run_scan(len, SHAPE_WIDE);
            phase_items += len;
         end else begin
            while (phase_items < 150) begin
               len = ($urandom_range(9) == 0) ? $urandom_range(40, 100) :
                     $urandom_range(1, 16);
               run_scan(len, count_shape_type'($urandom_range(3)));
               phase_items += len;
            end
         end
         random_items += phase_items;
         phase++;
      end

      no_idle = 1'b0;
      wait_drained();
      repeat (8) @(negedge clock);
      $display("covered %0d blocks in %0d checked scans over %0d register settings",
               tracker.blocks_seen, tracker.summaries_checked, settings_used);
      $display("%0d mismatches", tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("[wear_level_scan] OK");
      end else begin
         $display("[wear_level_scan] ERROR");
      end
      $finish;
   end

endmodule
